/* design/rtd_pkg.sv */
// Shared types, constants and the PT100 resistance table for the RTD converter.
`default_nettype none
package rtd_pkg;

	localparam int TABLE_ENTRIES = 65;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);   // holds 0..64
	localparam int RES_W         = 16;
	localparam int TEMP_W        = 16;
	localparam int HALF_W        = 5;                       // 16 down to 0
	localparam int DIFF_W        = 9;                       // table steps stay below 512
	localparam int SCALE_W       = 10;
	localparam int PROD_W        = DIFF_W + SCALE_W;
	localparam int QUO_W         = 10;                      // quotient never exceeds 1000
	localparam int CNT_W         = 4;
	localparam int SEARCH_STEPS  = 6;
	localparam int DIV_STEPS     = QUO_W;
	localparam int LAST_CHECKED  = 63;

	localparam logic [SCALE_W-1:0] SCALE_PER_STEP = SCALE_W'(1000);
	localparam logic [HALF_W-1:0]  HALF_INIT      = HALF_W'(16);
	localparam logic [IDX_W-1:0]   IDX_INIT       = IDX_W'(32);
	localparam logic [TEMP_W-1:0]  TEMP_MAX_VALID = TEMP_W'(64000);

	localparam logic [RES_W-1:0] RTD_ROM [0:TABLE_ENTRIES-1] = '{
		16'd10000, 16'd10390, 16'd10779, 16'd11167, 16'd11554, 16'd11940, 16'd12324,
		16'd12708, 16'd13090, 16'd13471, 16'd13851, 16'd14229, 16'd14607, 16'd14983,
		16'd15358, 16'd15733, 16'd16105, 16'd16477, 16'd16848, 16'd17217, 16'd17586,
		16'd17953, 16'd18319, 16'd18684, 16'd19047, 16'd19410, 16'd19771, 16'd20131,
		16'd20490, 16'd20848, 16'd21205, 16'd21561, 16'd21915, 16'd22268, 16'd22621,
		16'd22972, 16'd23321, 16'd23670, 16'd24018, 16'd24364, 16'd24709, 16'd25053,
		16'd25396, 16'd25738, 16'd26078, 16'd26418, 16'd26756, 16'd27093, 16'd27429,
		16'd27764, 16'd28098, 16'd28430, 16'd28762, 16'd29092, 16'd29421, 16'd29749,
		16'd30075, 16'd30401, 16'd30725, 16'd31049, 16'd31371, 16'd31692, 16'd32012,
		16'd32330, 16'd32648
	};

	localparam logic [RES_W-1:0] ROM_LOW  = RTD_ROM[0];
	localparam logic [RES_W-1:0] ROM_HIGH = RTD_ROM[LAST_CHECKED];

	// Indexes past the end read the last entry.
	function automatic logic [RES_W-1:0] rtd_rom(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] sel;
		sel = (idx > IDX_W'(TABLE_ENTRIES - 1)) ? IDX_W'(TABLE_ENTRIES - 1) : idx;
		return RTD_ROM[sel];
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} rtd_state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic search;
		logic setup;
		logic mul;
		logic div_step;
		logic out_load;
	} rtd_cmd_t;

	typedef struct packed {
		logic out_of_range;
	} rtd_status_t;

endpackage
`default_nettype wire

/* design/rtd_datapath.sv */
// Datapath: range check, table search, interpolation multiply, serial divider, result register.
`default_nettype none
module rtd_datapath
	import rtd_pkg::*;
(
	input  wire logic              clk,
	input  wire rtd_cmd_t          cmd,
	input  wire logic [RES_W-1:0]  res_in,
	output rtd_status_t            status,
	output logic [TEMP_W-1:0]      temperature,
	output logic                   out_of_range
);

	logic [RES_W-1:0]  res_q;
	logic [IDX_W-1:0]  idx_q;
	logic [HALF_W-1:0] half_q;
	logic              up_q;
	logic              oor_q;
	logic [DIFF_W-1:0] num_q;
	logic [DIFF_W-1:0] den_q;
	logic [DIFF_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [TEMP_W-1:0] temp_q;
	logic              oor_out_q;

	logic              above;
	logic [RES_W-1:0]  t_i;
	logic [RES_W-1:0]  t_nb;
	logic [IDX_W-1:0]  nb_idx;
	logic [RES_W-1:0]  num_full;
	logic [RES_W-1:0]  den_full;
	logic [PROD_W-1:0] prod;
	logic [DIFF_W:0]   trial;
	logic              qbit;
	logic [TEMP_W-1:0] base;
	logic [TEMP_W-1:0] interp;

	assign above    = res_q > rtd_rom(idx_q);
	assign t_i      = rtd_rom(idx_q);
	assign nb_idx   = up_q ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
	assign t_nb     = rtd_rom(nb_idx);
	assign num_full = up_q ? (res_q - t_i) : (t_i - res_q);
	assign den_full = up_q ? (t_nb - t_i) : (t_i - t_nb);
	assign prod     = PROD_W'(num_q) * PROD_W'(SCALE_PER_STEP);
	assign trial    = {rem_q, quo_q[QUO_W-1]};
	assign qbit     = trial >= {1'b0, den_q};
	assign base     = TEMP_W'(idx_q) * TEMP_W'(SCALE_PER_STEP);
	assign interp   = up_q ? (base + TEMP_W'(quo_q)) : (base - TEMP_W'(quo_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q  <= res_in;
			idx_q  <= IDX_INIT;
			half_q <= HALF_INIT;
			up_q   <= 1'b0;
		end
		if (cmd.check) begin
			oor_q <= (res_q < ROM_LOW) || (res_q > ROM_HIGH);
		end
		if (cmd.search) begin
			idx_q  <= above ? (idx_q + IDX_W'(half_q)) : (idx_q - IDX_W'(half_q));
			half_q <= half_q >> 1;
			up_q   <= above;
		end
		if (cmd.setup) begin
			num_q <= num_full[DIFF_W-1:0];
			den_q <= den_full[DIFF_W-1:0];
		end
		// The scaled numerator is below den * 2^QUO_W, so its upper bits seed the remainder.
		if (cmd.mul) begin
			rem_q <= prod[PROD_W-1:QUO_W];
			quo_q <= prod[QUO_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? DIFF_W'(trial - {1'b0, den_q}) : trial[DIFF_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
		if (cmd.out_load) begin
			temp_q    <= oor_q ? '0 : interp;
			oor_out_q <= oor_q;
		end
	end

	assign status.out_of_range = oor_q;
	assign temperature         = temp_q;
	assign out_of_range        = oor_out_q;

endmodule
`default_nettype wire

/* design/rtd_controller.sv */
// Controller: sequences check, search, multiply and divide steps and owns the handshakes.
`default_nettype none
module rtd_controller
	import rtd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire rtd_status_t status,
	output rtd_cmd_t         cmd
);

	rtd_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		in_ready    = 1'b0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cnt_d     = '0;
				state_d   = ST_SEARCH;
			end
			ST_SEARCH: begin
				// The range flag was registered in the check cycle.
				if (status.out_of_range) begin
					state_d = ST_DONE;
				end else begin
					cmd.search = 1'b1;
					cnt_d      = cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SEARCH_STEPS - 1)) begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// The output register takes a new beat once it is empty or being drained.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* design/rtd_resistance_to_temperature_unit.sv */
// Top level of the PT100 resistance-to-temperature converter.
//
// One beat on the slave stream carries a resistance in 0.01 ohm units (s_tdata).
// One beat on the master stream returns the temperature in 0.01 degree C
// (m_tdata) and an out-of-range flag (m_tuser). Every input beat yields
// exactly one output beat, in order.
// An input beat is taken only when the unit is idle. An in-range value then
// passes through a range check, six table search steps, a setup step, a
// multiply step and ten restoring-divider steps before its result is
// registered; an out-of-range value skips the search and the divide.
// A new beat is taken only after the last one has left the sequencer, as
// the search and the one-bit-per-cycle divider share one sequencer.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and processed, and it waits in its final state
// until the output register is drained.
// The asynchronous reset empties the output register and returns the
// sequencer to idle; the table is constant and needs no initialization.
`default_nettype none
module rtd_resistance_to_temperature_unit
	import rtd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [RES_W-1:0]  s_tdata,   // [15:0] resistance_centiohm
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [TEMP_W-1:0]      m_tdata,   // [15:0] temperature_centideg
	output logic                   m_tuser    // [0] out_of_range
);

	rtd_cmd_t    cmd;
	rtd_status_t status;

	rtd_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	rtd_datapath u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.res_in       (s_tdata),
		.status       (status),
		.temperature  (m_tdata),
		.out_of_range (m_tuser)
	);

	// The sequencer holds one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// An out-of-range result carries zero temperature.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range beat with nonzero temperature");

	// Interpolated temperatures stay within the table span.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= TEMP_MAX_VALID)
		else $error("temperature beyond table span");

endmodule
`default_nettype wire
